// ===== sv/wbps_pkg.sv =====
// ----------------------------------------------------------------------------
// Wildcard byte pattern scanner package
// Shared types, register indexes and constants for the scanner block.
// ----------------------------------------------------------------------------
package wbps_pkg;

	localparam int MAX_PATTERN_DEF = 16;
	localparam int LEN_W           = 5;
	localparam int PAT_W           = 128;
	localparam logic [7:0] WILDCARD_BYTE = 8'h3F;

	typedef enum logic [1:0] {
		CFG_PATTERN_LOW  = 2'd0,
		CFG_PATTERN_HIGH = 2'd1,
		CFG_PATTERN_LEN  = 2'd2,
		CFG_WILDCARD_EN  = 2'd3
	} cfg_index_t;

	typedef struct packed {
		logic [7:0]  data_byte;
		logic        region_first;
		logic [31:0] region_base;
	} in_item_t;

	typedef struct packed {
		logic [31:0] match_address;
		logic [31:0] match_offset;
	} out_item_t;

	// Pattern setup as seen by the matcher; length is already clamped
	typedef struct packed {
		logic [PAT_W-1:0] pattern;
		logic [LEN_W-1:0] length;
		logic             wildcard_en;
	} cfg_t;

endpackage

// ===== sv/wbps_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// Scanner configuration registers
// Holds the pattern, its clamped length and the wildcard enable.
// ----------------------------------------------------------------------------
module wbps_cfg_regs #(
	parameter int MAX_PATTERN = wbps_pkg::MAX_PATTERN_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 wr_en,
	input  wbps_pkg::cfg_index_t wr_index,
	input  logic [63:0]          wr_data,
	output wbps_pkg::cfg_t       cfg
);

	logic [63:0]                pat_low_q;
	logic [63:0]                pat_high_q;
	logic [wbps_pkg::LEN_W-1:0] len_q;
	logic                       wild_q;
	logic [wbps_pkg::LEN_W-1:0] len_raw;
	logic [wbps_pkg::LEN_W-1:0] len_clamped;

	assign len_raw = wr_data[wbps_pkg::LEN_W-1:0];

	// Zero counts as one, anything past the window depth as the full depth
	always_comb begin
		if (len_raw == '0) begin
			len_clamped = wbps_pkg::LEN_W'(1);
		end else if (len_raw > wbps_pkg::LEN_W'(MAX_PATTERN)) begin
			len_clamped = wbps_pkg::LEN_W'(MAX_PATTERN);
		end else begin
			len_clamped = len_raw;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pat_low_q  <= '0;
			pat_high_q <= '0;
			len_q      <= wbps_pkg::LEN_W'(1);
			wild_q     <= 1'b1;
		end else if (wr_en) begin
			unique case (wr_index)
				wbps_pkg::CFG_PATTERN_LOW:  pat_low_q  <= wr_data;
				wbps_pkg::CFG_PATTERN_HIGH: pat_high_q <= wr_data;
				wbps_pkg::CFG_PATTERN_LEN:  len_q      <= len_clamped;
				wbps_pkg::CFG_WILDCARD_EN:  wild_q     <= wr_data[0];
				default: ;
			endcase
		end
	end

	assign cfg.pattern     = {pat_high_q, pat_low_q};
	assign cfg.length      = len_q;
	assign cfg.wildcard_en = wild_q;

endmodule

// ===== sv/wbps_window_match.sv =====
// ----------------------------------------------------------------------------
// Scanner byte window and comparator
// Shifts each byte into the window and compares every pattern position
// against the updated window in parallel.
// ----------------------------------------------------------------------------
module wbps_window_match #(
	parameter int MAX_PATTERN = wbps_pkg::MAX_PATTERN_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           advance,
	input  logic [7:0]     data_byte,
	input  logic           region_first,
	input  wbps_pkg::cfg_t cfg,
	output logic           hit
);

	localparam int IDX_W = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;

	logic [7:0]             win_q    [MAX_PATTERN];
	logic [7:0]             win_next [MAX_PATTERN];
	logic [MAX_PATTERN-1:0] lane_ok;

	// Newest byte at entry 0; a region start clears the older entries
	assign win_next[0] = data_byte;

	for (genvar j = 1; j < MAX_PATTERN; j++) begin : g_shift
		assign win_next[j] = region_first ? 8'h00 : win_q[j-1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int j = 0; j < MAX_PATTERN; j++) begin
				win_q[j] <= '0;
			end
		end else if (advance) begin
			win_q <= win_next;
		end
	end

	// Pattern byte k lines up with the byte that arrived length-1-k items ago
	for (genvar k = 0; k < MAX_PATTERN; k++) begin : g_lane
		logic                       used;
		logic [wbps_pkg::LEN_W-1:0] lag;
		logic [IDX_W-1:0]           idx;
		logic [7:0]                 pbyte;

		assign used  = cfg.length > wbps_pkg::LEN_W'(k);
		assign lag   = cfg.length - wbps_pkg::LEN_W'(k + 1);
		assign idx   = used ? lag[IDX_W-1:0] : '0;
		assign pbyte = cfg.pattern[k*8 +: 8];

		assign lane_ok[k] = !used
			|| (cfg.wildcard_en && (pbyte == wbps_pkg::WILDCARD_BYTE))
			|| (pbyte == win_next[idx]);
	end

	assign hit = &lane_ok;

endmodule

// ===== sv/wildcard_byte_pattern_scanner.sv =====
// ----------------------------------------------------------------------------
// Wildcard byte pattern scanner
// Reports each non-overlapping occurrence of a pattern of up to
// MAX_PATTERN bytes, with optional '?' wildcards, in a stream of regions.
// ----------------------------------------------------------------------------
//  channel | signals                        | moves
//  --------+--------------------------------+-----------------------------
//  in      | in_valid, in_stall, in_data    | one region byte per transfer
//  out     | out_valid, out_stall, out_data | one match per transfer
//  cfg     | cfg_valid, cfg_ready, index    | one register write
//
// One byte per cycle while in_stall is low: the window shift, all
// lane compares and the count/suppression update sit between the state
// registers and the output register, so a match appears in the cycle
// after its last byte. Reset clears the window, counts and output valid;
// the pattern resets to length 1, wildcards on. in_stall rises only while
// a match waits in the output register and out_stall is high.
// ----------------------------------------------------------------------------
module wildcard_byte_pattern_scanner #(
	parameter int MAX_PATTERN = wbps_pkg::MAX_PATTERN_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  wbps_pkg::in_item_t   in_data,
	output logic                 out_valid,
	input  logic                 out_stall,
	output wbps_pkg::out_item_t  out_data,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  wbps_pkg::cfg_index_t cfg_index,
	input  logic [63:0]          cfg_data
);

	localparam int SUP_W = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;

	wbps_pkg::cfg_t      cfg;
	wbps_pkg::out_item_t out_q;
	logic                out_valid_q;
	logic                accept;
	logic                raw_hit;
	logic                hit;
	logic [31:0]         count_q;
	logic [31:0]         addr_q;
	logic [SUP_W-1:0]    sup_q;
	logic [31:0]         count_base;
	logic [31:0]         addr_base;
	logic [SUP_W-1:0]    sup_base;
	logic [31:0]         count_next;
	logic [31:0]         addr_next;
	logic [SUP_W-1:0]    sup_next;
	logic [31:0]         len_ext;

	assign cfg_ready = 1'b1;
	assign in_stall  = out_valid_q & out_stall;
	assign accept    = in_valid & !in_stall;

	wbps_cfg_regs #(
		.MAX_PATTERN (MAX_PATTERN)
	) u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid & cfg_ready),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	wbps_window_match #(
		.MAX_PATTERN (MAX_PATTERN)
	) u_match (
		.clk          (clk),
		.arst_n       (arst_n),
		.advance      (accept),
		.data_byte    (in_data.data_byte),
		.region_first (in_data.region_first),
		.cfg          (cfg),
		.hit          (raw_hit)
	);

	assign len_ext = 32'(cfg.length);

	// addr_q tracks region base plus byte count, so both results need one subtract
	always_comb begin
		count_base = in_data.region_first ? '0 : count_q;
		addr_base  = in_data.region_first ? in_data.region_base : addr_q;
		sup_base   = in_data.region_first ? '0 : sup_q;

		if (count_base == 32'hFFFF_FFFF) begin
			count_next = count_base;
			addr_next  = addr_base;
		end else begin
			count_next = count_base + 32'd1;
			addr_next  = addr_base + 32'd1;
		end

		hit      = 1'b0;
		sup_next = '0;
		if (sup_base != '0) begin
			sup_next = sup_base - SUP_W'(1);
		end else if (count_next >= len_ext) begin
			hit = raw_hit;
			if (raw_hit) begin
				sup_next = SUP_W'(cfg.length - wbps_pkg::LEN_W'(1));
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			addr_q  <= '0;
			sup_q   <= '0;
		end else if (accept) begin
			count_q <= count_next;
			addr_q  <= addr_next;
			sup_q   <= sup_next;
		end
	end

	// Output register: load on a match, drop once the transfer completes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept && hit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && hit) begin
			out_q.match_address <= addr_next - len_ext;
			out_q.match_offset  <= count_next - len_ext;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

// ===== tb/wbps_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pattern scanner checker
// Watches the byte, match and register channels of the scanner, keeps its
// own copy of the pattern setup and the scan state, predicts each match on
// the byte transfer that completes it and compares every match transfer
// field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module wbps_checker (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	input  logic                 in_stall,
	input  wbps_pkg::in_item_t   in_data,
	input  logic                 out_valid,
	input  logic                 out_stall,
	input  wbps_pkg::out_item_t  out_data,
	input  logic                 cfg_valid,
	input  logic                 cfg_ready,
	input  wbps_pkg::cfg_index_t cfg_index,
	input  logic [63:0]          cfg_data,
	output int                   mismatches,
	output int                   pending
);

	// pattern setup as last written
	logic [wbps_pkg::PAT_W-1:0] pattern;
	logic [wbps_pkg::LEN_W-1:0] pat_len;
	logic                       wild_en;

	// scan state
	logic [7:0]  window [wbps_pkg::MAX_PATTERN_DEF];
	logic [31:0] byte_total;
	logic [31:0] region_start;
	logic [4:0]  skip_left;

	wbps_pkg::out_item_t due_matches [$];

	task automatic clear_scan();
		int k;
		for (k = 0; k < wbps_pkg::MAX_PATTERN_DEF; k++)
			window[k] = '0;
		byte_total = '0;
		skip_left  = '0;
	endtask

	// shift one byte in and queue the match it completes, if any
	task automatic scan_byte(input wbps_pkg::in_item_t item);
		int                  k;
		int                  idx;
		logic [4:0]          span;
		logic                hit;
		logic [7:0]          want_byte;
		wbps_pkg::out_item_t found;
		if (item.region_first) begin
			clear_scan();
			region_start = item.region_base;
		end
		for (k = wbps_pkg::MAX_PATTERN_DEF - 1; k > 0; k--)
			window[k] = window[k-1];
		window[0] = item.data_byte;
		if (byte_total != 32'hFFFF_FFFF)
			byte_total++;
		span = (pat_len == 0) ? 5'd1 : ((pat_len > 5'd16) ? 5'd16 : pat_len);
		if (skip_left != 0) begin
			skip_left--;
		end else if (byte_total >= 32'(span)) begin
			hit = 1'b1;
			for (k = 0; k < int'(span); k++) begin
				want_byte = pattern[8*k +: 8];
				idx = (int'(span) - 1 - k) & (wbps_pkg::MAX_PATTERN_DEF - 1);
				if (!(wild_en && want_byte == wbps_pkg::WILDCARD_BYTE)
						&& want_byte != window[idx])
					hit = 1'b0;
			end
			if (hit) begin
				found.match_offset  = byte_total - 32'(span);
				found.match_address = region_start + found.match_offset;
				due_matches.insert(due_matches.size(), found);
				skip_left = span - 5'd1;
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		wbps_pkg::out_item_t want;
		if (!arst_n) begin
			pattern      = '0;
			pat_len      = 5'd1;
			wild_en      = 1'b1;
			region_start = '0;
			clear_scan();
			due_matches.delete();
			mismatches   = 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (due_matches.size() == 0) begin
					$display("%0t match transfer with none due: address %h offset %h",
						$time, out_data.match_address, out_data.match_offset);
					mismatches++;
				end else begin
					want = due_matches.pop_front();
					if (out_data.match_address !== want.match_address) begin
						$display("%0t match_address: expected %h, got %h",
							$time, want.match_address, out_data.match_address);
						mismatches++;
					end
					if (out_data.match_offset !== want.match_offset) begin
						$display("%0t match_offset: expected %h, got %h",
							$time, want.match_offset, out_data.match_offset);
						mismatches++;
					end
				end
			end
			// a byte taken on the same edge as a register write still sees the old setup
			if (in_valid && !in_stall)
				scan_byte(in_data);
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					wbps_pkg::CFG_PATTERN_LOW:  pattern[63:0]   = cfg_data;
					wbps_pkg::CFG_PATTERN_HIGH: pattern[127:64] = cfg_data;
					wbps_pkg::CFG_PATTERN_LEN:  pat_len         = cfg_data[4:0];
					wbps_pkg::CFG_WILDCARD_EN:  wild_en         = cfg_data[0];
					default: ;
				endcase
			end
		end
		pending = due_matches.size();
	end

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pattern scanner testbench
// Drives region byte streams into the scanner under a range of pattern
// setups, with random gaps on the byte side and random stalls on the match
// side, and leaves checking to the checker beside the block.
// ----------------------------------------------------------------------------
module testbench;

	logic                 clk;
	logic                 arst_n;
	logic                 in_valid;
	logic                 in_stall;
	wbps_pkg::in_item_t   in_data;
	logic                 out_valid;
	logic                 out_stall;
	wbps_pkg::out_item_t  out_data;
	logic                 cfg_valid;
	logic                 cfg_ready;
	wbps_pkg::cfg_index_t cfg_index;
	logic [63:0]          cfg_data;

	int mismatches;
	int pending;
	int tx_idle_pct;
	int rx_idle_pct;
	int hold_seq;

	// pattern as last loaded, for building streams that hit it
	logic [127:0] cur_pat;
	int           cur_len;

	wildcard_byte_pattern_scanner DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	wbps_checker match_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.in_data    (in_data),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.out_data   (out_data),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.mismatches (mismatches),
		.pending    (pending)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	initial begin
		#5_000_000;
		$display("[FAIL] regression broken");
		$finish;
	end

	// match side: random stalls, plus one long hold-off on request
	initial begin
		int stall_left;
		int hold_seen;
		stall_left = 0;
		hold_seen  = 0;
		out_stall  = 1'b0;
		forever begin
			@(negedge clk);
			if (stall_left > 0) begin
				out_stall <= 1'b1;
				stall_left--;
			end else if (hold_seq != hold_seen) begin
				hold_seen  = hold_seq;
				stall_left = 299;
				out_stall  <= 1'b1;
			end else begin
				out_stall <= ($urandom_range(0, 99) < rx_idle_pct);
			end
		end
	end

	task automatic send_byte(input logic [7:0] b, input logic first, input logic [31:0] base);
		@(negedge clk);
		while ($urandom_range(0, 99) < tx_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= {b, first, base};
		do @(posedge clk); while (in_stall);
	endtask

	task automatic write_reg(input wbps_pkg::cfg_index_t idx, input logic [63:0] value);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// drop valid and wait until every due match has gone out
	task automatic settle();
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic load_pattern(input logic [63:0] lo, input logic [63:0] hi,
			input logic [4:0] len, input logic wild);
		settle();
		write_reg(wbps_pkg::CFG_PATTERN_LOW, lo);
		write_reg(wbps_pkg::CFG_PATTERN_HIGH, hi);
		write_reg(wbps_pkg::CFG_PATTERN_LEN, {59'd0, len});
		write_reg(wbps_pkg::CFG_WILDCARD_EN, {63'd0, wild});
		cur_pat = {hi, lo};
		cur_len = (len == 0) ? 1 : ((len > 5'd16) ? 16 : int'(len));
	endtask

	function automatic logic [63:0] random_pattern_word();
		logic [63:0] w;
		int k;
		for (k = 0; k < 8; k++) begin
			case ($urandom_range(0, 5))
				0, 1:    w[8*k +: 8] = wbps_pkg::WILDCARD_BYTE;
				2:       w[8*k +: 8] = 8'h00;
				3:       w[8*k +: 8] = 8'hFF;
				default: w[8*k +: 8] = 8'($urandom_range(0, 255));
			endcase
		end
		return w;
	endfunction

	// regions of random length, seeded with whole and cut-short copies of the
	// pattern; the rest is noise drawn partly from the pattern's own bytes
	task automatic random_traffic(input int count);
		int sent;
		int region_len;
		int i;
		int copy_pos;
		int copy_stop;
		logic [7:0] b;
		logic first;
		logic [31:0] base;
		sent = 0;
		while (sent < count) begin
			region_len = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 120)
				: $urandom_range(1, 24);
			base     = $urandom;
			copy_pos = -1;
			for (i = 0; i < region_len && sent < count; i++) begin
				if (copy_pos < 0 && $urandom_range(0, 2) == 0) begin
					copy_pos  = 0;
					copy_stop = ($urandom_range(0, 4) == 0) ? $urandom_range(1, cur_len)
						: cur_len;
				end
				if (copy_pos >= 0) begin
					b = cur_pat[8*copy_pos +: 8];
					if (b == wbps_pkg::WILDCARD_BYTE && $urandom_range(0, 1) == 1)
						b = 8'($urandom_range(0, 255));
					copy_pos++;
					if (copy_pos >= copy_stop)
						copy_pos = -1;
				end else begin
					case ($urandom_range(0, 3))
						0:       b = 8'($urandom_range(0, 255));
						1:       b = cur_pat[8*$urandom_range(0, cur_len - 1) +: 8];
						2:       b = wbps_pkg::WILDCARD_BYTE;
						default: b = cur_pat[7:0];
					endcase
				end
				// now and then run on into the next region without a mark
				first = (i == 0) && ($urandom_range(0, 7) != 0);
				send_byte(b, first, base);
				sent++;
			end
		end
	endtask

	initial begin
		int s;
		int guard;
		logic [63:0] lo;
		logic [63:0] hi;
		logic [4:0]  len;
		logic        wild;

		arst_n      = 1'b0;
		in_valid    = 1'b0;
		in_data     = '0;
		cfg_valid   = 1'b0;
		cfg_index   = wbps_pkg::CFG_PATTERN_LOW;
		cfg_data    = '0;
		tx_idle_pct = 9;
		rx_idle_pct = 45;
		hold_seq    = 0;
		cur_pat     = '0;
		cur_len     = 1;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// reset pattern: single byte 0x00, bytes before any region mark
		send_byte(8'h00, 1'b0, 32'hFFFF_FFFF);
		send_byte(8'hFF, 1'b0, 32'h0000_0000);
		send_byte(8'h00, 1'b0, 32'h1234_5678);

		// "A?C" with wildcards: match at the top of the address space,
		// none across a region boundary, and a literal '?' in the data
		load_pattern(64'h0000_0000_0043_3F41, 64'd0, 5'd3, 1'b1);
		send_byte(8'h41, 1'b1, 32'hFFFF_FFFF);
		send_byte(8'h5A, 1'b0, 32'h0);
		send_byte(8'h43, 1'b0, 32'h0);
		send_byte(8'h41, 1'b1, 32'h0);
		send_byte(8'h42, 1'b0, 32'h0);
		send_byte(8'h43, 1'b1, 32'h0000_0010);
		send_byte(8'h41, 1'b0, 32'h0);
		send_byte(8'h3F, 1'b0, 32'h0);
		send_byte(8'h43, 1'b0, 32'h0);

		// exact compare: '?' only matches itself
		load_pattern(64'h0000_0000_0043_3F41, 64'd0, 5'd3, 1'b0);
		send_byte(8'h41, 1'b1, 32'h8000_0000);
		send_byte(8'h3F, 1'b0, 32'h0);
		send_byte(8'h43, 1'b0, 32'h0);
		send_byte(8'h41, 1'b0, 32'h0);
		send_byte(8'h42, 1'b0, 32'h0);
		send_byte(8'h43, 1'b0, 32'h0);

		// "AA" over "AAAA": the third byte may not complete an overlapping match
		load_pattern(64'h4141, 64'd0, 5'd2, 1'b0);
		repeat (4) send_byte(8'h41, 1'b1 && 1'b0, 32'h0);
		send_byte(8'h41, 1'b1, 32'hFFFF_FFF0);
		// length zero behaves as one
		load_pattern(64'hFF, 64'd0, 5'd0, 1'b1);
		send_byte(8'hFF, 1'b1, 32'h0);

		for (s = 0; s < 10; s++) begin
			if (s == 4) begin
				tx_idle_pct = 45;
				rx_idle_pct = 9;
			end else if (s == 7) begin
				tx_idle_pct = 0;
				rx_idle_pct = 0;
			end
			case (s)
				4: begin
					lo = '1;
					hi = '1;
				end
				5: begin
					lo = '0;
					hi = '0;
				end
				default: begin
					lo = random_pattern_word();
					hi = random_pattern_word();
				end
			endcase
			case (s)
				0:       len = 5'd1;
				1:       len = 5'd16;
				2:       len = 5'd0;
				3:       len = 5'd31;
				default: len = 5'($urandom_range(0, 20));
			endcase
			wild = (s == 6) ? 1'b0 : ((s == 7) ? 1'b1 : 1'($urandom_range(0, 1)));
			load_pattern(lo, hi, len, wild);
			// single-byte pattern matches often: hold the match side off so
			// the output fills and the byte side backs up
			if (s == 0)
				hold_seq++;
			random_traffic(200);
		end

		@(negedge clk);
		in_valid <= 1'b0;
		guard = 0;
		while (pending != 0 && guard < 20000) begin
			@(negedge clk);
			guard++;
		end
		repeat (8) @(negedge clk);
		if (mismatches == 0 && pending == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

// ===== files.f =====
sv/wbps_pkg.sv
sv/wbps_cfg_regs.sv
sv/wbps_window_match.sv
sv/wildcard_byte_pattern_scanner.sv
tb/wbps_checker.sv
tb/testbench.sv
